// ===== hdl/twps_pkg.sv =====
// Shared types and constants of the tuple position-weight scorer.
`timescale 1ns / 1ps
`default_nettype none

package twps_pkg;

  localparam int unsigned LANES    = 4;   // tuple registers, one read lane each
  localparam int unsigned TUPLE_W  = 8;
  localparam int unsigned BASE_W   = 2;
  localparam int unsigned WIN_W    = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned TBL_DEPTH = 128;
  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned SEQ_W    = 6;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic [LEN_W-1:0] RST_TUPLE_LEN   = 3'd1;
  localparam logic [LEN_W-1:0] RST_TUPLE_COUNT = 3'd1;
  localparam logic [SEQ_W-1:0] RST_SEQ_LEN     = 6'd25;

  typedef enum logic [2:0] {
    REG_TUPLE_LEN   = 3'd0,
    REG_TUPLE_COUNT = 3'd1,
    REG_SEQ_LEN     = 3'd2,
    REG_TUPLE_A     = 3'd3,
    REG_TUPLE_B     = 3'd4,
    REG_TUPLE_C     = 3'd5,
    REG_TUPLE_D     = 3'd6
  } reg_idx_e;

  typedef enum logic {
    ACT_BASE   = 1'b0,
    ACT_WEIGHT = 1'b1
  } action_e;

  typedef struct packed {
    logic [LEN_W-1:0]                 tuple_len;
    logic [LEN_W-1:0]                 tuple_count;
    logic [SEQ_W-1:0]                 seq_len;
    logic [LANES-1:0][TUPLE_W-1:0]    tuples;
  } cfg_t;

  typedef struct packed {
    logic             last;
    logic [LANES-1:0] hit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/twps_in_if.sv =====
// Input channel: base or weight-write items.
`timescale 1ns / 1ps
`default_nettype none

interface twps_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic [twps_pkg::BASE_W-1:0]            base;
  logic [twps_pkg::IDX_W-1:0]             weight_index;
  logic signed [twps_pkg::WEIGHT_W-1:0]   weight_value;

  modport source (output valid, action, base, weight_index, weight_value, input ready);
  modport sink   (input valid, action, base, weight_index, weight_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/twps_out_if.sv =====
// Output channel: one score item per sequence.
`timescale 1ns / 1ps
`default_nettype none

interface twps_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [twps_pkg::SUM_W-1:0]   increment;
  logic [twps_pkg::CNT_W-1:0]          match_count;
  logic                                saturated;

  modport source (output valid, increment, match_count, saturated, input ready);
  modport sink   (input valid, increment, match_count, saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/twps_wmem.sv =====
// One bank of the weight table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module twps_wmem (
  input  wire logic                              clk_i,
  input  wire logic                              wr_en_i,
  input  wire logic [twps_pkg::IDX_W-1:0]        wr_addr_i,
  input  wire logic [twps_pkg::WEIGHT_W-1:0]     wr_data_i,
  input  wire logic                              rd_en_i,
  input  wire logic [twps_pkg::IDX_W-1:0]        rd_addr_i,
  output logic      [twps_pkg::WEIGHT_W-1:0]     rd_data_o
);

  logic [twps_pkg::WEIGHT_W-1:0] mem [twps_pkg::TBL_DEPTH];
  logic [twps_pkg::WEIGHT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/twps_match.sv =====
// Front stage: base window, position, tuple compares and table addresses.
`timescale 1ns / 1ps
`default_nettype none

module twps_match #(
  parameter int unsigned RANK_CAP = 4,
  parameter int unsigned LANE_CAP = 4,
  parameter int unsigned SEQ_CAP  = 32
) (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire twps_pkg::cfg_t                                  cfg_i,
  input  wire logic                                            accept_i,
  input  wire logic [twps_pkg::BASE_W-1:0]                     base_i,
  output twps_pkg::cmd_t                                       cmd_o,
  output logic [twps_pkg::LANES-1:0][twps_pkg::IDX_W-1:0]      rd_addr_o
);

  localparam int unsigned PW = twps_pkg::POS_W + 1;

  logic [twps_pkg::WIN_W-1:0] window_q, window_d;
  logic [twps_pkg::POS_W-1:0] pos_q, pos_d;

  logic [twps_pkg::LEN_W-1:0] len_eff;
  logic [twps_pkg::LEN_W-1:0] cnt_eff;
  logic [twps_pkg::SEQ_W-1:0] slen_eff;
  logic [twps_pkg::WIN_W-1:0] win_new;
  logic [PW-1:0]              pos_nx;
  logic [PW-1:0]              start;
  logic [PW-1:0]              valid_n;
  logic                       in_range;

  // Compare the newest len bases (top of the window) with a tuple's low bits.
  function automatic logic tuple_hit(input logic [twps_pkg::WIN_W-1:0] win,
                                     input logic [twps_pkg::TUPLE_W-1:0] tup,
                                     input logic [twps_pkg::LEN_W-1:0] len);
    logic hit;
    case (len)
      3'd1:    hit = (tup[1:0] == win[7:6]);
      3'd2:    hit = (tup[3:0] == win[7:4]);
      3'd3:    hit = (tup[5:0] == win[7:2]);
      default: hit = (tup == win);
    endcase
    return hit;
  endfunction

  always_comb begin
    len_eff = cfg_i.tuple_len;
    if (len_eff == '0) begin
      len_eff = 3'd1;
    end
    if (len_eff > twps_pkg::LEN_W'(RANK_CAP)) begin
      len_eff = twps_pkg::LEN_W'(RANK_CAP);
    end
    cnt_eff = cfg_i.tuple_count;
    if (cnt_eff > twps_pkg::LEN_W'(LANE_CAP)) begin
      cnt_eff = twps_pkg::LEN_W'(LANE_CAP);
    end
    slen_eff = cfg_i.seq_len;
    if (slen_eff == '0) begin
      slen_eff = 6'd1;
    end
    if (slen_eff > twps_pkg::SEQ_W'(SEQ_CAP)) begin
      slen_eff = twps_pkg::SEQ_W'(SEQ_CAP);
    end
  end

  assign win_new  = {base_i, window_q[twps_pkg::WIN_W-1:twps_pkg::BASE_W]};
  assign pos_nx   = PW'(pos_q) + PW'(1);
  assign in_range = (pos_nx >= PW'(len_eff)) && (pos_nx <= PW'(slen_eff));
  assign start    = pos_nx - PW'(len_eff);
  assign valid_n  = PW'(slen_eff) - PW'(len_eff) + PW'(1);

  for (genvar l = 0; l < twps_pkg::LANES; l++) begin : g_lane
    if (l < LANE_CAP) begin : g_used
      assign cmd_o.hit[l] = in_range && (twps_pkg::LEN_W'(l) < cnt_eff) &&
                            tuple_hit(win_new, cfg_i.tuples[l], len_eff);
    end else begin : g_unused
      assign cmd_o.hit[l] = 1'b0;
    end
    // Wraps modulo the table depth.
    assign rd_addr_o[l] = twps_pkg::IDX_W'(valid_n * PW'(l) + start);
  end

  assign cmd_o.last = (pos_nx >= PW'(slen_eff));

  always_comb begin
    window_d = window_q;
    pos_d    = pos_q;
    if (accept_i) begin
      if (cmd_o.last) begin
        window_d = '0;
        pos_d    = '0;
      end else begin
        window_d = win_new;
        pos_d    = pos_nx[twps_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      pos_q    <= '0;
    end else begin
      window_q <= window_d;
      pos_q    <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/twps_accum.sv =====
// Accumulate stage: one saturating add per matched lane, result register.
`timescale 1ns / 1ps
`default_nettype none

module twps_accum (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire logic                                            load_i,
  input  wire twps_pkg::cmd_t                                  cmd_i,
  input  wire logic [twps_pkg::LANES-1:0][twps_pkg::WEIGHT_W-1:0] rdata_i,
  output logic                                                 ready_o,
  input  wire logic                                            out_ready_i,
  output logic                                                 out_valid_o,
  output logic signed [twps_pkg::SUM_W-1:0]                    increment_o,
  output logic [twps_pkg::CNT_W-1:0]                           match_count_o,
  output logic                                                 saturated_o
);

  localparam int unsigned SEL_W = (twps_pkg::LANES > 1) ? $clog2(twps_pkg::LANES) : 1;
  localparam int unsigned EXT_W = twps_pkg::SUM_W + 1;

  logic                                s1_valid_q;
  twps_pkg::cmd_t                      cmd_q;
  logic signed [twps_pkg::SUM_W-1:0]   acc_q, acc_n;
  logic [twps_pkg::CNT_W-1:0]          cnt_q, cnt_n;
  logic                                clip_q, clip_n;
  logic                                out_valid_q;
  logic signed [twps_pkg::SUM_W-1:0]   out_inc_q;
  logic [twps_pkg::CNT_W-1:0]          out_cnt_q;
  logic                                out_sat_q;

  logic [SEL_W-1:0]                    sel;
  logic [twps_pkg::LANES-1:0]          rem;
  logic [twps_pkg::WEIGHT_W-1:0]       w;
  logic [EXT_W-1:0]                    sum_ext;
  logic                                ovf;
  logic                                any_hit;
  logic                                out_free;
  logic                                step;
  logic                                done;

  // Lowest pending lane goes first.
  always_comb begin
    sel = '0;
    for (int l = twps_pkg::LANES - 1; l >= 0; l--) begin
      if (cmd_q.hit[l]) begin
        sel = SEL_W'(l);
      end
    end
  end

  assign rem     = cmd_q.hit & (cmd_q.hit - twps_pkg::LANES'(1));
  assign any_hit = |cmd_q.hit;
  assign w       = rdata_i[sel];
  assign sum_ext = {acc_q[twps_pkg::SUM_W-1], acc_q} +
                   {{(EXT_W - twps_pkg::WEIGHT_W){w[twps_pkg::WEIGHT_W-1]}}, w};
  assign ovf     = sum_ext[EXT_W-1] != sum_ext[EXT_W-2];

  always_comb begin
    acc_n  = acc_q;
    cnt_n  = cnt_q;
    clip_n = clip_q;
    if (any_hit) begin
      cnt_n = cnt_q + twps_pkg::CNT_W'(1);
      if (ovf) begin
        clip_n = 1'b1;
        acc_n  = sum_ext[EXT_W-1] ? {1'b1, {(twps_pkg::SUM_W-1){1'b0}}}
                                  : {1'b0, {(twps_pkg::SUM_W-1){1'b1}}};
      end else begin
        acc_n = sum_ext[twps_pkg::SUM_W-1:0];
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign step     = s1_valid_q && ((rem != '0) || !cmd_q.last || out_free);
  assign done     = step && (rem == '0);
  assign ready_o  = !s1_valid_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      cmd_q       <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Take a new base over a finishing one; otherwise retire matched lanes.
      if (load_i) begin
        s1_valid_q <= 1'b1;
        cmd_q      <= cmd_i;
      end else begin
        if (done) begin
          s1_valid_q <= 1'b0;
        end
        if (step) begin
          cmd_q.hit <= rem;
        end
      end
      if (done && cmd_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (step) begin
        if (done && cmd_q.last) begin
          acc_q  <= '0;
          cnt_q  <= '0;
          clip_q <= 1'b0;
        end else begin
          acc_q  <= acc_n;
          cnt_q  <= cnt_n;
          clip_q <= clip_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && cmd_q.last) begin
      out_inc_q <= acc_n;
      out_cnt_q <= cnt_n;
      out_sat_q <= clip_n;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign increment_o   = out_inc_q;
  assign match_count_o = out_cnt_q;
  assign saturated_o   = out_sat_q;

`ifndef SYNTHESIS
  // A new result comes only from the closing base of a sequence.
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && cmd_q.last && done))
    else $error("result raised without a finishing last base");

  // A finished sequence waiting on a full result register is held.
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && cmd_q.last && (rem == '0) && out_valid_q && !out_ready_i)
    |=> (s1_valid_q && cmd_q.last))
    else $error("last base dropped while result register full");

  // No match means nothing was added.
  a_zero_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_cnt_q == '0)) |-> ((out_inc_q == '0) && !out_sat_q))
    else $error("nonzero score without matches");
`endif

endmodule

`default_nettype wire

// ===== hdl/tuple_position_weight_scorer.sv =====
// Top level of the tuple position-weight scorer: registers, banks, stages.
//
// Usage: item_in carries one item per valid/ready handshake. An item with
// action 0 is the next base of a probe sequence; action 1 writes one weight
// table entry and produces nothing. After seq_len bases one result item
// (saturated Q16.16 sum, match count, saturation flag) leaves on result_out.
// Registers are to be written over the APB port only while the block is idle;
// the block itself does not enforce this. Throughput: one base per cycle when
// at most one tuple matches at that position and no finished result waits on
// a stalled result_out; a base that matches more than one tuple holds the
// accumulate stage until every matched lane is added, since the running sum
// takes one saturating add per cycle. A weight write completes on acceptance.
// The last base's sum goes to the result register once its lanes are added.
// The weight table is replicated once per used tuple lane so that all lanes
// read in the same cycle; entries are undefined until written.
// Reset clears the window, position, sum, count and result valid flag and
// loads register defaults. If result_out stalls, the finished result holds
// and the block keeps taking items until the next sequence end needs the
// result register.
`timescale 1ns / 1ps
`default_nettype none

module tuple_position_weight_scorer #(
  parameter int unsigned MAX_TUPLES = 4,
  parameter int unsigned MAX_RANK   = 4,
  parameter int unsigned MAX_SEQ    = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  twps_in_if.sink                                 item_in,
  twps_out_if.source                              result_out,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [twps_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [twps_pkg::DATA_W-1:0]        pwdata,
  output logic      [twps_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready
);

  // Caps on lanes, tuple length and sequence length.
  localparam int unsigned LANE_CAP = (MAX_TUPLES < twps_pkg::LANES) ? MAX_TUPLES
                                                                    : twps_pkg::LANES;
  localparam int unsigned RANK_CAP = (MAX_RANK < 4) ? MAX_RANK : 4;
  localparam int unsigned SEQ_MAXV = (1 << twps_pkg::SEQ_W) - 1;
  localparam int unsigned SEQ_CAP  = (MAX_SEQ < SEQ_MAXV) ? MAX_SEQ : SEQ_MAXV;

  twps_pkg::cfg_t                                        cfg_q;
  twps_pkg::reg_idx_e                                    reg_idx;
  logic                                                  cfg_wr;
  logic                                                  accept;
  logic                                                  base_acc;
  logic                                                  wr_acc;
  logic                                                  acc_ready;
  twps_pkg::cmd_t                                        cmd;
  logic [twps_pkg::LANES-1:0][twps_pkg::IDX_W-1:0]       rd_addr;
  logic [twps_pkg::LANES-1:0][twps_pkg::WEIGHT_W-1:0]    rdata;

  // ---------------- configuration registers ----------------
  assign reg_idx = twps_pkg::reg_idx_e'(paddr[twps_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tuple_len   <= twps_pkg::RST_TUPLE_LEN;
      cfg_q.tuple_count <= twps_pkg::RST_TUPLE_COUNT;
      cfg_q.seq_len     <= twps_pkg::RST_SEQ_LEN;
      cfg_q.tuples      <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        twps_pkg::REG_TUPLE_LEN:   cfg_q.tuple_len   <= pwdata[twps_pkg::LEN_W-1:0];
        twps_pkg::REG_TUPLE_COUNT: cfg_q.tuple_count <= pwdata[twps_pkg::LEN_W-1:0];
        twps_pkg::REG_SEQ_LEN:     cfg_q.seq_len     <= pwdata[twps_pkg::SEQ_W-1:0];
        twps_pkg::REG_TUPLE_A:     cfg_q.tuples[0]   <= pwdata[twps_pkg::TUPLE_W-1:0];
        twps_pkg::REG_TUPLE_B:     cfg_q.tuples[1]   <= pwdata[twps_pkg::TUPLE_W-1:0];
        twps_pkg::REG_TUPLE_C:     cfg_q.tuples[2]   <= pwdata[twps_pkg::TUPLE_W-1:0];
        twps_pkg::REG_TUPLE_D:     cfg_q.tuples[3]   <= pwdata[twps_pkg::TUPLE_W-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      twps_pkg::REG_TUPLE_LEN:   prdata = twps_pkg::DATA_W'(cfg_q.tuple_len);
      twps_pkg::REG_TUPLE_COUNT: prdata = twps_pkg::DATA_W'(cfg_q.tuple_count);
      twps_pkg::REG_SEQ_LEN:     prdata = twps_pkg::DATA_W'(cfg_q.seq_len);
      twps_pkg::REG_TUPLE_A:     prdata = twps_pkg::DATA_W'(cfg_q.tuples[0]);
      twps_pkg::REG_TUPLE_B:     prdata = twps_pkg::DATA_W'(cfg_q.tuples[1]);
      twps_pkg::REG_TUPLE_C:     prdata = twps_pkg::DATA_W'(cfg_q.tuples[2]);
      twps_pkg::REG_TUPLE_D:     prdata = twps_pkg::DATA_W'(cfg_q.tuples[3]);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- item handshake ----------------
  assign item_in.ready = acc_ready;
  assign accept   = item_in.valid && acc_ready;
  assign base_acc = accept && (item_in.action == twps_pkg::ACT_BASE);
  assign wr_acc   = accept && (item_in.action == twps_pkg::ACT_WEIGHT);

  // ---------------- front stage ----------------
  twps_match #(
    .RANK_CAP (RANK_CAP),
    .LANE_CAP (LANE_CAP),
    .SEQ_CAP  (SEQ_CAP)
  ) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (base_acc),
    .base_i    (item_in.base),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  // ---------------- weight table, one copy per lane ----------------
  // Every copy takes each write; each lane reads its own copy.
  for (genvar l = 0; l < twps_pkg::LANES; l++) begin : g_bank
    if (l < LANE_CAP) begin : g_mem
      twps_wmem u_wmem (
        .clk_i     (clk_i),
        .wr_en_i   (wr_acc),
        .wr_addr_i (item_in.weight_index),
        .wr_data_i (item_in.weight_value),
        .rd_en_i   (base_acc),
        .rd_addr_i (rd_addr[l]),
        .rd_data_o (rdata[l])
      );
    end else begin : g_none
      assign rdata[l] = '0;  // lane never hits
    end
  end

  // ---------------- accumulate stage and result register ----------------
  twps_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (base_acc),
    .cmd_i         (cmd),
    .rdata_i       (rdata),
    .ready_o       (acc_ready),
    .out_ready_i   (result_out.ready),
    .out_valid_o   (result_out.valid),
    .increment_o   (result_out.increment),
    .match_count_o (result_out.match_count),
    .saturated_o   (result_out.saturated)
  );

endmodule

`default_nettype wire
